### hw/rtl/ilt_pkg.sv
// ----------------------------------------------------------------------------
// ilt_pkg
// shared types, widths and codes of the interpolating lookup table
// ----------------------------------------------------------------------------
package ilt_pkg;

  // default table depth
  localparam int unsigned DEPTH_DEF = 256;

  // field widths
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned DIFF_W    = VAL_W + 1;
  localparam int unsigned QUO_W     = VAL_W + FRAC_W;

  // depth of the queue between front and back
  localparam int unsigned Q_DEPTH = 4;

  // item modes
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLAMP = 2'd2,
    MODE_WRAP  = 2'd3
  } mode_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_MIN = 2'd0,
    CFG_RANGE_MAX = 2'd1,
    CFG_STEP_SIZE = 2'd2,
    CFG_ENTRIES   = 2'd3
  } cfg_reg_t;

  // classified operations handed to the back end
  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ,
    OP_FIRST,
    OP_LAST,
    OP_ZERO,
    OP_CLAMP,
    OP_WRAP
  } op_t;

  // configuration as seen by front and back (n already saturated)
  typedef struct packed {
    logic signed [VAL_W-1:0] range_min;
    logic signed [VAL_W-1:0] range_max;
    logic [STEP_W-1:0]       step;
    logic [CNT_W-1:0]        n;
  } cfg_t;

  // queue word
  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic [DIFF_W-1:0] arg;
  } item_t;

endpackage

### hw/rtl/ilt_if.sv
// ----------------------------------------------------------------------------
// ilt channel interfaces
// input, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface ilt_in_if import ilt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              mode;
  logic [IDX_W-1:0]        entry_index;
  logic signed [VAL_W-1:0] entry_value;
  logic signed [VAL_W-1:0] query_x;

  modport source (output valid, mode, entry_index, entry_value, query_x, input ready);
  modport sink (input valid, mode, entry_index, entry_value, query_x, output ready);
endinterface

interface ilt_out_if import ilt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] result_value;

  modport source (output valid, result_value, input ready);
  modport sink (input valid, result_value, output ready);
endinterface

interface ilt_cfg_if import ilt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VAL_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/ilt_front.sv
// ----------------------------------------------------------------------------
// ilt_front
// accepts input words and classifies them into back end operations
// ----------------------------------------------------------------------------
module ilt_front import ilt_pkg::*; (
  input  cfg_t      cfg,
  ilt_in_if.sink    in_if,
  input  logic      q_full,
  output logic      push,
  output item_t     push_item
);

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] period;
  logic                     idx_ok;
  logic                     keep;

  // position relative to range start and period
  assign dx     = $signed({in_if.query_x[VAL_W-1], in_if.query_x})
                - $signed({cfg.range_min[VAL_W-1], cfg.range_min});
  assign period = $signed({cfg.range_max[VAL_W-1], cfg.range_max})
                - $signed({cfg.range_min[VAL_W-1], cfg.range_min});
  assign idx_ok = {1'b0, in_if.entry_index} < cfg.n;

  // classification
  always_comb begin
    keep           = 1'b1;
    push_item.op   = OP_ZERO;
    push_item.idx  = in_if.entry_index;
    push_item.arg  = dx;
    unique case (mode_t'(in_if.mode))
      MODE_WRITE: begin
        push_item.op  = OP_WRITE;
        push_item.arg = {1'b0, in_if.entry_value};
        keep          = idx_ok;
      end
      MODE_READ: begin
        push_item.op = idx_ok ? OP_READ : OP_ZERO;
      end
      MODE_CLAMP: begin
        if (cfg.n == '0)
          push_item.op = OP_ZERO;
        else if (cfg.n == CNT_W'(1) || $signed(in_if.query_x) <= $signed(cfg.range_min))
          push_item.op = OP_FIRST;
        else if ($signed(in_if.query_x) >= $signed(cfg.range_max) || cfg.step == '0)
          push_item.op = OP_LAST;
        else
          push_item.op = OP_CLAMP;
      end
      MODE_WRAP: begin
        if (cfg.n == '0)
          push_item.op = OP_ZERO;
        else if (cfg.n == CNT_W'(1) || period <= 0 || cfg.step == '0)
          push_item.op = OP_FIRST;
        else
          push_item.op = OP_WRAP;
      end
      default: push_item.op = OP_ZERO;
    endcase
  end

  // handshake
  assign in_if.ready = !q_full;
  assign push        = in_if.valid && !q_full && keep;

endmodule

### hw/rtl/ilt_queue.sv
// ----------------------------------------------------------------------------
// ilt_queue
// short fifo between the classifying front and the back end pipeline
// ----------------------------------------------------------------------------
module ilt_queue import ilt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  avail,
  output item_t head
);

  localparam int unsigned PW = $clog2(Q_DEPTH);
  localparam int unsigned CW = $clog2(Q_DEPTH + 1);

  item_t          slot_r [Q_DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt;
  logic [PW-1:0]  rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  // pointer and count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(Q_DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop)
      cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push)
      cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_item;
    end
  end

  assign full  = cnt_r == CW'(Q_DEPTH);
  assign avail = cnt_r != '0;
  assign head  = slot_r[rd_r];

endmodule

### hw/rtl/ilt_back.sv
// ----------------------------------------------------------------------------
// ilt_back
// pipelined wrap, position divide, table read and linear blend
// ----------------------------------------------------------------------------
module ilt_back import ilt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_avail,
  input  item_t     q_head,
  output logic      pop,
  ilt_out_if.source out_if
);

  localparam int unsigned STORE_DEPTH = (TABLE_DEPTH < (1 << IDX_W)) ? TABLE_DEPTH
                                                                    : (1 << IDX_W);
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
  localparam int unsigned MOD_N       = DIFF_W;
  localparam int unsigned DIV_N       = QUO_W;

  logic                 adv;
  logic [VAL_W-1:0]     per;
  logic [DIFF_W-1:0]    per_full;
  logic [CNT_W-1:0]     n1;

  // whole pipeline moves when the output register is free
  assign adv      = !out_if.valid || out_if.ready;
  assign pop      = adv && q_avail;
  assign per_full = {cfg.range_max[VAL_W-1], cfg.range_max}
                  - {cfg.range_min[VAL_W-1], cfg.range_min};
  assign per      = per_full[VAL_W-1:0];
  assign n1       = cfg.n - CNT_W'(1);

  // --------------------------------------------------------------------------
  // wrap: restoring remainder of |x - min| by the period, one bit per stage
  // --------------------------------------------------------------------------
  logic              mv_r   [MOD_N];
  op_t               mop_r  [MOD_N];
  logic [IDX_W-1:0]  midx_r [MOD_N];
  logic              mneg_r [MOD_N];
  logic [DIFF_W-1:0] mdv_r  [MOD_N];
  logic [VAL_W-1:0]  mrem_r [MOD_N];

  for (genvar k = 0; k < MOD_N; k++) begin : g_mod
    logic              pv;
    op_t               pop_c;
    logic [IDX_W-1:0]  pidx;
    logic              pneg;
    logic [DIFF_W-1:0] pdv;
    logic [VAL_W-1:0]  prem;
    logic [DIFF_W-1:0] t;
    logic              ge;

    if (k == 0) begin : g_first
      assign pv    = q_avail;
      assign pop_c = q_head.op;
      assign pidx  = q_head.idx;
      assign pneg  = (q_head.op == OP_WRAP) && q_head.arg[DIFF_W-1];
      assign pdv   = pneg ? (DIFF_W'(0) - q_head.arg) : q_head.arg;
      assign prem  = '0;
    end else begin : g_next
      assign pv    = mv_r[k-1];
      assign pop_c = mop_r[k-1];
      assign pidx  = midx_r[k-1];
      assign pneg  = mneg_r[k-1];
      assign pdv   = mdv_r[k-1];
      assign prem  = mrem_r[k-1];
    end

    assign t  = {prem, pdv[DIFF_W-1]};
    assign ge = t >= {1'b0, per};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mv_r[k] <= 1'b0;
      end else if (adv) begin
        mv_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        mop_r[k]  <= pop_c;
        midx_r[k] <= pidx;
        mneg_r[k] <= pneg;
        if (pop_c == OP_WRAP) begin
          mrem_r[k] <= ge ? VAL_W'(t - {1'b0, per}) : t[VAL_W-1:0];
          mdv_r[k]  <= {pdv[DIFF_W-2:0], 1'b0};
        end else begin
          mrem_r[k] <= prem;
          mdv_r[k]  <= pdv;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // wrap fix-up: negative offsets fold back into the period
  // --------------------------------------------------------------------------
  logic             fv_r;
  op_t              fop_r;
  logic [IDX_W-1:0] fidx_r;
  logic [VAL_W-1:0] fnum_r;
  logic [VAL_W-1:0] fnum_c;

  always_comb begin
    if (mop_r[MOD_N-1] == OP_WRAP) begin
      if (mneg_r[MOD_N-1] && mrem_r[MOD_N-1] != '0)
        fnum_c = per - mrem_r[MOD_N-1];
      else
        fnum_c = mrem_r[MOD_N-1];
    end else begin
      fnum_c = mdv_r[MOD_N-1][VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (adv) begin
      fv_r <= mv_r[MOD_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fop_r  <= mop_r[MOD_N-1];
      fidx_r <= midx_r[MOD_N-1];
      fnum_r <= fnum_c;
    end
  end

  // --------------------------------------------------------------------------
  // position: restoring divide of offset * 2^16 by the step, one bit per stage
  // --------------------------------------------------------------------------
  logic              dv_r   [DIV_N];
  op_t               dop_r  [DIV_N];
  logic [IDX_W-1:0]  didx_r [DIV_N];
  logic [STEP_W-1:0] drem_r [DIV_N];
  logic [QUO_W-1:0]  dq_r   [DIV_N];

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    logic              pv;
    op_t               pop_c;
    logic [IDX_W-1:0]  pidx;
    logic [STEP_W-1:0] prem;
    logic [QUO_W-1:0]  pq;
    logic [VAL_W-1:0]  t;
    logic              ge;

    if (k == 0) begin : g_first
      assign pv    = fv_r;
      assign pop_c = fop_r;
      assign pidx  = fidx_r;
      assign prem  = '0;
      assign pq    = {fnum_r, FRAC_W'(0)};
    end else begin : g_next
      assign pv    = dv_r[k-1];
      assign pop_c = dop_r[k-1];
      assign pidx  = didx_r[k-1];
      assign prem  = drem_r[k-1];
      assign pq    = dq_r[k-1];
    end

    assign t  = {prem, pq[QUO_W-1]};
    assign ge = t >= {1'b0, cfg.step};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else if (adv) begin
        dv_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dop_r[k]  <= pop_c;
        didx_r[k] <= pidx;
        if (pop_c == OP_CLAMP || pop_c == OP_WRAP) begin
          drem_r[k] <= ge ? STEP_W'(t - {1'b0, cfg.step}) : t[STEP_W-1:0];
          dq_r[k]   <= {pq[QUO_W-2:0], ge};
        end else begin
          drem_r[k] <= prem;
          dq_r[k]   <= pq;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // decode: entry addresses and blend fraction
  // --------------------------------------------------------------------------
  logic              ev_r;
  op_t               eop_r;
  logic [CNT_W-1:0]  ea_r, eb_r;
  logic [FRAC_W-1:0] ef_r;
  logic              ezero_r;
  logic [VAL_W-1:0]  edata_r;

  logic [CNT_W-1:0]  ea_c, eb_c;
  logic [FRAC_W-1:0] ef_c;
  logic              ezero_c;
  logic [QUO_W-1:0]  q_c;
  logic [VAL_W-1:0]  base_c;

  assign q_c    = dq_r[DIV_N-1];
  assign base_c = q_c[QUO_W-1:FRAC_W];

  always_comb begin
    ea_c    = '0;
    eb_c    = '0;
    ef_c    = '0;
    ezero_c = 1'b0;
    case (dop_r[DIV_N-1]) inside
      OP_CLAMP, OP_WRAP: begin
        // past the second to last entry both modes give the last entry
        if (base_c >= VAL_W'(n1)) begin
          ea_c = n1;
        end else begin
          ea_c = base_c[CNT_W-1:0];
          eb_c = base_c[CNT_W-1:0] + CNT_W'(1);
          ef_c = q_c[FRAC_W-1:0];
        end
      end
      OP_READ, OP_WRITE: ea_c = {1'b0, didx_r[DIV_N-1]};
      OP_FIRST:          ea_c = '0;
      OP_LAST:           ea_c = n1;
      default:           ezero_c = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r <= 1'b0;
    end else if (adv) begin
      ev_r <= dv_r[DIV_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      eop_r   <= dop_r[DIV_N-1];
      ea_r    <= ea_c;
      eb_r    <= eb_c;
      ef_r    <= ef_c;
      ezero_r <= ezero_c;
      edata_r <= q_c[QUO_W-1:FRAC_W];
    end
  end

  // --------------------------------------------------------------------------
  // table: one write port, two registered read ports, valid bit per entry
  // --------------------------------------------------------------------------
  logic [VAL_W-1:0]       mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vbit_r;
  logic                   gv_r, gout_r;
  logic [FRAC_W-1:0]      gf_r;
  logic [VAL_W-1:0]       rda_r, rdb_r;
  logic                   oka_r, okb_r;
  logic                   wr_en;
  logic                   ina, inb;

  assign wr_en = adv && ev_r && eop_r == OP_WRITE;
  assign ina   = ea_r < CNT_W'(STORE_DEPTH);
  assign inb   = eb_r < CNT_W'(STORE_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbit_r <= '0;
    end else if (wr_en) begin
      vbit_r[ea_r[STORE_AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ea_r[STORE_AW-1:0]] <= edata_r;
    end
    if (adv) begin
      rda_r <= mem[ea_r[STORE_AW-1:0]];
      rdb_r <= mem[eb_r[STORE_AW-1:0]];
      oka_r <= !ezero_r && ina && vbit_r[ea_r[STORE_AW-1:0]];
      okb_r <= !ezero_r && inb && vbit_r[eb_r[STORE_AW-1:0]];
      gf_r  <= ef_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gv_r   <= 1'b0;
      gout_r <= 1'b0;
    end else if (adv) begin
      gv_r   <= ev_r;
      gout_r <= eop_r != OP_WRITE;
    end
  end

  // --------------------------------------------------------------------------
  // blend: (b - a) * frac, then a * 2^16 plus product, rounded
  // --------------------------------------------------------------------------
  logic signed [VAL_W-1:0]        a_c, b_c;
  logic signed [DIFF_W-1:0]       diff_c;
  logic signed [DIFF_W+FRAC_W:0]  prod_c;
  logic                           hv_r, hout_r;
  logic signed [VAL_W-1:0]        ha_r;
  logic signed [DIFF_W+FRAC_W:0]  hprod_r;

  assign a_c    = oka_r ? rda_r : '0;
  assign b_c    = okb_r ? rdb_r : '0;
  assign diff_c = $signed({b_c[VAL_W-1], b_c}) - $signed({a_c[VAL_W-1], a_c});
  assign prod_c = diff_c * $signed({1'b0, gf_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r   <= 1'b0;
      hout_r <= 1'b0;
    end else if (adv) begin
      hv_r   <= gv_r;
      hout_r <= gout_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ha_r    <= a_c;
      hprod_r <= prod_c;
    end
  end

  // final sum and output register
  logic signed [DIFF_W+FRAC_W+1:0] sum_c;
  logic                            out_valid_r;
  logic signed [VAL_W-1:0]         out_value_r;

  assign sum_c = $signed({{3{ha_r[VAL_W-1]}}, ha_r, FRAC_W'(0)})
               + $signed({hprod_r[DIFF_W+FRAC_W], hprod_r})
               + $signed((DIFF_W+FRAC_W+2)'(1 << (FRAC_W - 1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= hv_r && hout_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value_r <= sum_c[VAL_W+FRAC_W-1:FRAC_W];
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.result_value = out_value_r;

endmodule

### hw/rtl/interpolating_lookup_table_top.sv
// ----------------------------------------------------------------------------
// interpolating_lookup_table_top
// uniformly spaced q16.16 table with read, write and interpolated lookups
// ----------------------------------------------------------------------------
// channels: in_if carries one word per item (mode, entry_index, entry_value,
// query_x); out_if returns result_value for reads and lookups, nothing for
// writes; cfg_if writes range_min, range_max, step_size and entries_in_use
// and is always ready. configure only while no items are in flight.
// pipeline: the word enters the queue at the edge that accepts it, then the
// 33 stage wrap remainder, its fix-up, the 48 stage position divider, the
// decode, the table read and the two blend stages follow. throughput: one
// word per cycle while the receiver does not stall.
// the front classifies words into a 4 word queue; the back pipeline moves
// only when its output register is free, so a stalled receiver holds the
// result, backs up the queue and then drops in_if.ready.
// reset: registers return to 0, 65536, 0, 0 and every table entry reads as
// zero at once through per entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module interpolating_lookup_table_top import ilt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ilt_in_if.sink    in_if,
  ilt_out_if.source out_if,
  ilt_cfg_if.sink   cfg_if
);

  localparam int unsigned NCAP = (TABLE_DEPTH < (1 << CNT_W) - 1) ? TABLE_DEPTH
                                                                  : (1 << CNT_W) - 1;

  logic signed [VAL_W-1:0] range_min_r;
  logic signed [VAL_W-1:0] range_max_r;
  logic [STEP_W-1:0]       step_size_r;
  logic [CNT_W-1:0]        entries_r;
  cfg_t                    cfg;

  logic  push, q_full, q_avail, pop;
  item_t push_item, q_head;

  // configuration registers
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r <= '0;
      range_max_r <= VAL_W'(1 << FRAC_W);
      step_size_r <= '0;
      entries_r   <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_reg_t'(cfg_if.index))
        CFG_RANGE_MIN: range_min_r <= cfg_if.data;
        CFG_RANGE_MAX: range_max_r <= cfg_if.data;
        CFG_STEP_SIZE: step_size_r <= cfg_if.data[STEP_W-1:0];
        CFG_ENTRIES:   entries_r   <= cfg_if.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // active entry count saturated to the table depth
  always_comb begin
    cfg.range_min = range_min_r;
    cfg.range_max = range_max_r;
    cfg.step      = step_size_r;
    cfg.n         = (entries_r > CNT_W'(NCAP)) ? CNT_W'(NCAP) : entries_r;
  end

  ilt_front u_front (
    .cfg       (cfg),
    .in_if     (in_if),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  ilt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .avail     (q_avail),
    .head      (q_head)
  );

  ilt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_avail (q_avail),
    .q_head  (q_head),
    .pop     (pop),
    .out_if  (out_if)
  );

endmodule

### tb/ilt_lookup_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ilt_lookup_checker
// watches the configuration, input and result channels of the lookup table,
// keeps its own copy of registers and entries, predicts every result word
// and compares it field by field in order of arrival
// ----------------------------------------------------------------------------
module ilt_lookup_checker import ilt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ilt_in_if    in_w,
  ilt_out_if   res_w,
  ilt_cfg_if   cfg_w,
  output int   pending,
  output int   checked,
  output int   fail_count
);

  localparam int unsigned DEPTH = DEPTH_DEF;

  // shadow registers and entries
  longint          lo_bound;
  longint          hi_bound;
  longint          spacing;
  longint          count_reg;
  logic [VAL_W-1:0] entries [DEPTH];

  // expected result words, oldest first
  logic signed [VAL_W-1:0] results_due[$];

  function automatic longint active_entries();
    return (count_reg > DEPTH) ? longint'(DEPTH) : count_reg;
  endfunction

  function automatic longint entry_val(longint i);
    if (i < 0 || i >= DEPTH) return 0;
    return longint'(signed'(entries[i]));
  endfunction

  // linear blend, rounded to nearest with ties upward
  function automatic longint mix_pair(longint a, longint b, longint f);
    longint sum;
    sum = a * (65536 - f) + b * f;
    return (sum + 32768) >>> 16;
  endfunction

  function automatic longint clamped_value(longint x);
    longint n, pos, base;
    n = active_entries();
    if (n == 0) return 0;
    if (n == 1) return entry_val(0);
    if (x <= lo_bound) return entry_val(0);
    if (x >= hi_bound || spacing == 0) return entry_val(n - 1);
    pos = ((x - lo_bound) <<< 16) / spacing;
    base = pos >>> 16;
    if (base >= n - 1) return entry_val(n - 1);
    return mix_pair(entry_val(base), entry_val(base + 1), pos & 64'hFFFF);
  endfunction

  function automatic longint periodic_value(longint x);
    longint n, period, r, pos, base, frac;
    n = active_entries();
    if (n == 0) return 0;
    if (n == 1) return entry_val(0);
    period = hi_bound - lo_bound;
    if (period <= 0 || spacing == 0) return entry_val(0);
    r = (x - lo_bound) % period;
    if (r < 0) r += period;
    pos = (r <<< 16) / spacing;
    base = pos >>> 16;
    if (base >= n - 1) base = n - 2;
    frac = pos - (base <<< 16);
    if (frac > 65536) frac = 65536;
    return mix_pair(entry_val(base), entry_val(base + 1), frac);
  endfunction

  // prediction, bookkeeping and comparison
  always @(posedge clk) begin
    longint x, n, res;
    logic signed [VAL_W-1:0] want;
    if (!rst_n) begin
      lo_bound = 0;
      hi_bound = 65536;
      spacing = 0;
      count_reg = 0;
      foreach (entries[i]) entries[i] = '0;
      results_due.delete();
      checked = 0;
      fail_count = 0;
    end else begin
      // register writes
      if (cfg_w.valid && cfg_w.ready) begin
        case (cfg_reg_t'(cfg_w.index))
          CFG_RANGE_MIN: lo_bound = longint'(signed'(cfg_w.data));
          CFG_RANGE_MAX: hi_bound = longint'(signed'(cfg_w.data));
          CFG_STEP_SIZE: spacing = longint'(cfg_w.data[STEP_W-1:0]);
          CFG_ENTRIES:   count_reg = longint'(cfg_w.data[CNT_W-1:0]);
          default: ;
        endcase
      end
      // accepted input word
      if (in_w.valid && in_w.ready) begin
        n = active_entries();
        x = longint'(in_w.query_x);
        case (mode_t'(in_w.mode))
          MODE_WRITE: begin
            if (in_w.entry_index < n) entries[in_w.entry_index] = in_w.entry_value;
          end
          MODE_READ: begin
            res = (in_w.entry_index < n) ? entry_val(in_w.entry_index) : 0;
            results_due.insert(results_due.size(), res[VAL_W-1:0]);
          end
          MODE_CLAMP: begin
            res = clamped_value(x);
            results_due.insert(results_due.size(), res[VAL_W-1:0]);
          end
          default: begin
            res = periodic_value(x);
            results_due.insert(results_due.size(), res[VAL_W-1:0]);
          end
        endcase
      end
      // accepted result word
      if (res_w.valid && res_w.ready) begin
        if (results_due.size() == 0) begin
          $error("result_value: no result expected, got %0d", res_w.result_value);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          checked++;
          if (res_w.result_value !== want) begin
            $error("result_value: expected %0d, got %0d", want, res_w.result_value);
            fail_count++;
          end
        end
      end
    end
    pending = results_due.size();
  end

endmodule

### tb/interpolating_lookup_table_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interpolating_lookup_table_top_test
// drives table writes, reads, clamped and periodic lookups through several
// range, spacing and size settings with random stalls on both sides; the
// checker beside the block predicts and compares every result word
// ----------------------------------------------------------------------------
module interpolating_lookup_table_top_test;
  import ilt_pkg::*;

  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst_n;
  int   pending;
  int   checked;
  int   fail_count;
  int   cycles;
  int   words_sent;
  int   send_idle;
  int   recv_idle;

  ilt_in_if  in_w ();
  ilt_out_if res_w ();
  ilt_cfg_if cfg_w ();

  interpolating_lookup_table_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_w),
    .out_if (res_w),
    .cfg_if (cfg_w)
  );

  ilt_lookup_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_w       (in_w),
    .res_w      (res_w),
    .cfg_w      (cfg_w),
    .pending    (pending),
    .checked    (checked),
    .fail_count (fail_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL interpolating_lookup_table_top");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    res_w.ready <= ($urandom_range(99) >= recv_idle);
  end

  // one input word, with random idle cycles before it
  task automatic push_word(mode_t m, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
                           logic [VAL_W-1:0] x);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_w.valid <= 1'b0;
      @(negedge clk);
    end
    in_w.valid       <= 1'b1;
    in_w.mode        <= m;
    in_w.entry_index <= idx;
    in_w.entry_value <= val;
    in_w.query_x     <= x;
    do @(posedge clk); while (!in_w.ready);
    words_sent++;
  endtask

  // stop sending and wait until every result is back and the pipe is empty
  task automatic drain();
    @(negedge clk);
    in_w.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [VAL_W-1:0] d);
    @(negedge clk);
    cfg_w.valid <= 1'b1;
    cfg_w.index <= r;
    cfg_w.data  <= d;
    do @(posedge clk); while (!cfg_w.ready);
  endtask

  task automatic set_table(longint lo, longint hi, longint stp, int cnt);
    write_reg(CFG_RANGE_MIN, lo[VAL_W-1:0]);
    write_reg(CFG_RANGE_MAX, hi[VAL_W-1:0]);
    write_reg(CFG_STEP_SIZE, stp[VAL_W-1:0]);
    write_reg(CFG_ENTRIES, cnt[VAL_W-1:0]);
    @(negedge clk);
    cfg_w.valid <= 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    longint lo, hi, stp, span, x;
    int     cnt, n_live, idx;
    mode_t  m;

    rst_n = 1'b0;
    send_idle = 37;
    recv_idle = 82;
    words_sent = 0;
    in_w.valid = 1'b0;
    in_w.mode = MODE_WRITE;
    in_w.entry_index = '0;
    in_w.entry_value = '0;
    in_w.query_x = '0;
    cfg_w.valid = 1'b0;
    cfg_w.index = CFG_RANGE_MIN;
    cfg_w.data = '0;
    res_w.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table after reset: ignored write, reads and lookups give zero
    push_word(MODE_WRITE, 8'd0, 32'h1234_5678, '0);
    push_word(MODE_READ, 8'd0, '0, '0);
    push_word(MODE_READ, 8'd255, '0, '0);
    push_word(MODE_CLAMP, '0, '0, 32'h0000_8000);
    push_word(MODE_WRAP, '0, '0, 32'h8000_0000);
    drain();

    // three entries at unit spacing, extreme values
    set_table(0, 2 * 65536, 65536, 3);
    push_word(MODE_WRITE, 8'd0, 32'h7FFF_FFFF, '0);
    push_word(MODE_WRITE, 8'd1, 32'h8000_0000, '0);
    push_word(MODE_WRITE, 8'd2, 32'hFFFF_FFFF, '0);
    push_word(MODE_WRITE, 8'd3, 32'h0000_0042, '0);
    push_word(MODE_READ, 8'd3, '0, '0);
    push_word(MODE_READ, 8'd1, '0, '0);
    push_word(MODE_CLAMP, '0, '0, 32'hFFFF_FFFF);
    push_word(MODE_CLAMP, '0, '0, 32'h0000_0000);
    push_word(MODE_CLAMP, '0, '0, 32'h0000_8000);
    push_word(MODE_CLAMP, '0, '0, 32'h0001_8000);
    push_word(MODE_CLAMP, '0, '0, 32'h0002_0000);
    push_word(MODE_CLAMP, '0, '0, 32'h7FFF_FFFF);
    push_word(MODE_WRAP, '0, '0, 32'h8000_0000);
    push_word(MODE_WRAP, '0, '0, 32'hFFFF_FFFF);
    push_word(MODE_WRAP, '0, '0, 32'h0003_0005);
    // hold off until the pipe is empty, then go on
    drain();

    // random phases over varied settings
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        send_idle = 82;
        recv_idle = 37;
      end else if (ph == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (ph)
        0: begin lo = -65536; hi = 65536; stp = 65536; cnt = 1; end
        1: begin lo = 0; hi = 255 * 65536; stp = 65536; cnt = 256; end
        2: begin lo = -64'sd2147483648; hi = 64'sd2147483647; stp = 64'h7FFF_FFFF; cnt = 300; end
        3: begin lo = 65536; hi = -65536; stp = 0; cnt = 8; end
        default: begin
          cnt  = ($urandom_range(7) == 0) ? $urandom_range(2, 256) : $urandom_range(2, 24);
          stp  = $urandom_range(1, 1 << 20);
          lo   = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
          hi   = lo + stp * (cnt - 1) + longint'($urandom_range(0, 4)) - 2;
        end
      endcase
      set_table(lo, hi, stp, cnt);
      n_live = (cnt > DEPTH_DEF) ? DEPTH_DEF : cnt;
      span = (hi > lo) ? hi - lo : 65536;

      // fill every live entry first
      for (int i = 0; i < n_live; i++) push_word(MODE_WRITE, i[IDX_W-1:0], pick_value(), '0);

      for (int k = 0; k < 60; k++) begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5: m = MODE_WRITE;
          6, 7, 8:          m = MODE_READ;
          9, 10, 11, 12, 13, 14: m = MODE_CLAMP;
          default:          m = MODE_WRAP;
        endcase
        idx = ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(n_live - 1);
        if ($urandom_range(9) < 7) begin
          x = lo - span / 8 + longint'($urandom_range(0, 32'hFFFF_FFFF)) % (span + span / 4 + 1);
          if (x > 64'sd2147483647) x = 64'sd2147483647;
          if (x < -64'sd2147483648) x = -64'sd2147483648;
        end else begin
          x = longint'($urandom());
        end
        push_word(m, idx[IDX_W-1:0], pick_value(), x[VAL_W-1:0]);
      end
      drain();
    end

    $display("covered %0d input words over 10 table settings, %0d result words checked",
             words_sent, checked);
    $display("settings included empty, single, full and oversized tables and reversed range");
    if (fail_count == 0) begin
      $display("PASS interpolating_lookup_table_top");
    end else begin
      $display("FAIL interpolating_lookup_table_top");
    end
    $finish;
  end

endmodule
